### design/mfp_pkg.sv
package mfp_pkg;

  localparam logic [7:0] HDR0    = 8'h55;
  localparam logic [7:0] HDR1    = 8'hAA;
  localparam logic [7:0] TAIL    = 8'hCC;
  localparam logic [7:0] CK_INIT = 8'hFF;

  localparam int unsigned WIN_DEPTH = 6;
  localparam int unsigned FRAME_LEN = 7;

  // decoded frame handed from the window logic to the result register
  typedef struct packed {
    logic               found;
    logic               ok;
    logic [7:0]         status;
    logic signed [15:0] position;
  } frame_t;

endpackage

### design/mfp_window.sv
module mfp_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [7:0]          rx_byte,
  output mfp_pkg::frame_t     frame
);

  logic [7:0] bytes [mfp_pkg::WIN_DEPTH];
  logic [7:0] bytes_next [mfp_pkg::WIN_DEPTH];
  logic [2:0] held;
  logic [2:0] held_next;

  logic [7:0] win [mfp_pkg::FRAME_LEN];
  logic       hdr_hit;
  logic [2:0] start;
  logic [2:0] from;
  logic       full;
  logic       found;
  logic [3:0] idx;
  logic [7:0] ck;

  assign full = (held >= 3'(mfp_pkg::WIN_DEPTH));

  always_comb begin
    for (int i = 0; i < int'(mfp_pkg::WIN_DEPTH); i++) begin
      win[i] = bytes[i];
    end
    win[mfp_pkg::WIN_DEPTH] = rx_byte;
  end

  // first header pair in the seven bytes wins
  always_comb begin
    hdr_hit = 1'b0;
    start   = '0;
    for (int i = int'(mfp_pkg::WIN_DEPTH) - 1; i >= 0; i--) begin
      if (win[i] == mfp_pkg::HDR0 && win[i + 1] == mfp_pkg::HDR1) begin
        hdr_hit = 1'b1;
        start   = 3'(i);
      end
    end
  end

  assign found = full && hdr_hit && (start == 3'd0) && (win[6] == mfp_pkg::TAIL);
  assign from  = (hdr_hit && start != 3'd0) ? start : 3'd1;
  assign ck    = mfp_pkg::CK_INIT ^ win[2] ^ win[3] ^ win[4];

  always_comb begin
    frame.found    = en && found;
    frame.ok       = (ck == win[5]);
    frame.status   = win[2];
    frame.position = {win[3], win[4]};
  end

  always_comb begin
    idx = '0;
    for (int i = 0; i < int'(mfp_pkg::WIN_DEPTH); i++) begin
      bytes_next[i] = bytes[i];
    end
    held_next = held;
    if (!full) begin
      bytes_next[held] = rx_byte;
      held_next        = held + 3'd1;
    end else if (found) begin
      held_next = '0;
    end else begin
      // keep the tail starting at the header or one past the oldest byte
      for (int i = 0; i < int'(mfp_pkg::WIN_DEPTH); i++) begin
        idx = {1'b0, from} + 4'(i);
        if (idx <= 4'(mfp_pkg::WIN_DEPTH)) begin
          bytes_next[i] = win[idx[2:0]];
        end
      end
      held_next = 3'(mfp_pkg::FRAME_LEN) - from;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < int'(mfp_pkg::WIN_DEPTH); i++) begin
        bytes[i] <= bytes_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (en) begin
      held <= held_next;
    end
  end

endmodule

### design/mfp_result.sv
module mfp_result (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  mfp_pkg::frame_t     frame,
  output logic                frame_valid,
  output logic                checksum_ok,
  output logic [7:0]          mirror_status,
  output logic                mirror_fault,
  output logic signed [15:0]  position,
  output logic [31:0]         frames_seen,
  output logic [31:0]         checksum_errors
);

  // counters change only when a new result is loaded, so they double as outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid     <= 1'b0;
      frames_seen     <= '0;
      checksum_errors <= '0;
    end else if (adv) begin
      frame_valid <= frame.found;
      if (frame.found) begin
        frames_seen <= frames_seen + 32'd1;
        if (!frame.ok) begin
          checksum_errors <= checksum_errors + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && frame.found) begin
      checksum_ok   <= frame.ok;
      mirror_status <= frame.status;
      mirror_fault  <= (frame.status != 8'd0);
      position      <= frame.position;
    end
  end

endmodule

### design/mirror_feedback_frame_parser.sv
// channel  | handshake                      | payload
// ---------+--------------------------------+---------------------------------------------
// receive  | rx_valid / rx_stall            | rx_byte
// frame    | frame_valid / frame_stall      | checksum_ok, mirror_status, mirror_fault,
//          |                                | position, frames_seen, checksum_errors
//
// one byte per cycle sustained while frame_stall stays low; a byte is registered,
// then goes through the window compare and shift, and a completed frame is loaded
// into the result register behind it; a result-side stall can hold it in between.
// rst (synchronous) empties the window, clears both counters and drops frame_valid.
// a stalled result holds; the byte register behind it holds too and rx_stall rises
// only while the byte register is full and the result register cannot move.
module mirror_feedback_frame_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  logic [7:0]          rx_byte,
  output logic                frame_valid,
  input  logic                frame_stall,
  output logic                checksum_ok,
  output logic [7:0]          mirror_status,
  output logic                mirror_fault,
  output logic signed [15:0]  position,
  output logic [31:0]         frames_seen,
  output logic [31:0]         checksum_errors
);

  // byte register in front of the window logic
  logic            byte_valid;
  logic [7:0]      byte_data;
  logic            adv;
  logic            fire;
  mfp_pkg::frame_t frame;

  // result register can take new data when empty or being drained
  assign adv      = !frame_valid || !frame_stall;
  // byte register empties whenever the pipe moves
  assign rx_stall = byte_valid && !adv;
  assign fire     = byte_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!rx_stall) begin
      byte_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      byte_data <= rx_byte;
    end
  end

  // sliding window, header search and check byte
  mfp_window u_window (
    .clk     (clk),
    .rst     (rst),
    .en      (fire),
    .rx_byte (byte_data),
    .frame   (frame)
  );

  // result register and wrapping counters
  mfp_result u_result (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .frame           (frame),
    .frame_valid     (frame_valid),
    .checksum_ok     (checksum_ok),
    .mirror_status   (mirror_status),
    .mirror_fault    (mirror_fault),
    .position        (position),
    .frames_seen     (frames_seen),
    .checksum_errors (checksum_errors)
  );

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int RANDOM_BYTES = 850;
  localparam int QUIET_TAIL   = 120;     // last bytes go out with no idling on either side
  localparam int SETTLE       = 12;      // extra clocks waited after the last expected frame
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [7:0] data;
    bit         drain;                   // hold this byte back until no frame is outstanding
  } rx_item_t;

  typedef struct {
    logic               ok;
    logic [7:0]         status;
    logic               fault;
    logic signed [15:0] position;
    logic [31:0]        frames;
    logic [31:0]        errors;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               frame_valid;
  logic               frame_stall = 1'b0;
  logic               checksum_ok;
  logic [7:0]         mirror_status;
  logic               mirror_fault;
  logic signed [15:0] position;
  logic [31:0]        frames_seen;
  logic [31:0]        checksum_errors;

  rx_item_t      rx_bytes_pending[$];
  frame_result_t frames_due[$];
  rx_item_t      next_item;
  frame_result_t got_frame;

  // deframer state kept by the testbench
  logic [7:0]  win_bytes[mfp_pkg::WIN_DEPTH];
  int unsigned win_held;
  logic [31:0] frame_total;
  logic [31:0] error_total;

  int unsigned bytes_accepted;
  int unsigned total_bytes;
  int unsigned mismatches;
  int unsigned rx_gap;
  int unsigned stall_left;
  int unsigned cycle_count;
  bit          mid_drain_done;

  mirror_feedback_frame_parser u_top (
    .clk             (clk),
    .rst             (rst),
    .rx_valid        (rx_valid),
    .rx_stall        (rx_stall),
    .rx_byte         (rx_byte),
    .frame_valid     (frame_valid),
    .frame_stall     (frame_stall),
    .checksum_ok     (checksum_ok),
    .mirror_status   (mirror_status),
    .mirror_fault    (mirror_fault),
    .position        (position),
    .frames_seen     (frames_seen),
    .checksum_errors (checksum_errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // keep the last bytes of a seven-byte window, starting at index from
  function automatic void keep_window_tail(logic [7:0] w[mfp_pkg::FRAME_LEN],
                                           int unsigned from);
    for (int i = 0; i < mfp_pkg::WIN_DEPTH; i++) win_bytes[i] = 8'h00;
    for (int i = 0; i < mfp_pkg::FRAME_LEN - from && i < mfp_pkg::WIN_DEPTH; i++) begin
      win_bytes[i] = w[from + i];
    end
    win_held = mfp_pkg::FRAME_LEN - from;
  endfunction

  // advance the deframer by one received byte, queue the frame it completes, if any
  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0]    w[mfp_pkg::FRAME_LEN];
    int            hdr_at;
    logic [7:0]    ck;
    frame_result_t fr;
    if (win_held < mfp_pkg::WIN_DEPTH) begin
      win_bytes[win_held] = b;
      win_held++;
      return;
    end
    for (int i = 0; i < mfp_pkg::WIN_DEPTH; i++) w[i] = win_bytes[i];
    w[mfp_pkg::WIN_DEPTH] = b;
    // first header pair anywhere in the window
    hdr_at = -1;
    for (int i = 0; i + 1 < mfp_pkg::FRAME_LEN; i++) begin
      if (hdr_at < 0 && w[i] == mfp_pkg::HDR0 && w[i + 1] == mfp_pkg::HDR1) hdr_at = i;
    end
    if (hdr_at < 0) begin
      keep_window_tail(w, 1);                 // no header: slide by one
    end else if (hdr_at > 0) begin
      keep_window_tail(w, unsigned'(hdr_at)); // drop what sits before the header
    end else if (w[6] != mfp_pkg::TAIL) begin
      keep_window_tail(w, 1);                 // header aligned, bad end byte
    end else begin
      frame_total = frame_total + 1;
      ck = mfp_pkg::CK_INIT ^ w[2] ^ w[3] ^ w[4];
      fr.ok = (ck == w[5]);
      if (!fr.ok) error_total = error_total + 1;
      fr.status   = w[2];
      fr.fault    = (w[2] != 8'h00);
      fr.position = {w[3], w[4]};
      fr.frames   = frame_total;
      fr.errors   = error_total;
      frames_due.push_back(fr);
      for (int i = 0; i < mfp_pkg::WIN_DEPTH; i++) win_bytes[i] = 8'h00;
      win_held = 0;
    end
  endfunction

  function automatic void push_byte(logic [7:0] b, bit drain = 1'b0);
    rx_item_t it;
    it.data  = b;
    it.drain = drain;
    rx_bytes_pending.push_back(it);
  endfunction

  // queue a seven-byte frame, optionally with a corrupted check or end byte
  function automatic void push_frame(logic [7:0] status, logic [15:0] pos,
                                     bit good_check, bit good_tail, bit drain = 1'b0);
    logic [7:0] ck;
    logic [7:0] tail_byte;
    ck = mfp_pkg::CK_INIT ^ status ^ pos[15:8] ^ pos[7:0];
    if (!good_check) ck = ck ^ 8'($urandom_range(1, 255));
    tail_byte = mfp_pkg::TAIL;
    if (!good_tail) tail_byte = mfp_pkg::TAIL ^ 8'($urandom_range(1, 255));
    push_byte(mfp_pkg::HDR0, drain);
    push_byte(mfp_pkg::HDR1);
    push_byte(status);
    push_byte(pos[15:8]);
    push_byte(pos[7:0]);
    push_byte(ck);
    push_byte(tail_byte);
  endfunction

  // noise biased toward the framing bytes so partial headers show up often
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0: return mfp_pkg::HDR0;
      1: return mfp_pkg::HDR1;
      2: return mfp_pkg::TAIL;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    int unsigned kind;
    logic [7:0]  status;
    for (int i = 0; i < mfp_pkg::WIN_DEPTH; i++) win_bytes[i] = 8'h00;
    win_held    = 0;
    frame_total = 0;
    error_total = 0;

    // directed: good frame, most negative position, zero status
    push_frame(8'h00, 16'h8000, 1'b1, 1'b1);
    // a stray byte ahead of the header, then all-ones status, most positive
    // position and a bad check byte
    push_byte(8'h00);
    push_frame(8'hFF, 16'h7FFF, 1'b0, 1'b1);
    // header at the start but the wrong end byte, followed by a window
    // with no header at all
    push_byte(mfp_pkg::HDR0);
    push_byte(mfp_pkg::HDR1);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h03);
    push_byte(8'h04);
    push_byte(8'h05);
    push_byte(8'hFF);

    // random part, opened by a full drain of the directed results
    push_frame(8'($urandom), 16'($urandom), 1'b1, 1'b1, 1'b1);
    while (rx_bytes_pending.size() < RANDOM_BYTES) begin
      kind   = $urandom_range(0, 99);
      status = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
      if (kind < 55) begin
        push_frame(status, 16'($urandom), 1'b1, 1'b1,
                   !mid_drain_done && rx_bytes_pending.size() > RANDOM_BYTES / 2);
        if (rx_bytes_pending.size() > RANDOM_BYTES / 2) mid_drain_done = 1'b1;
      end else if (kind < 70) begin
        push_frame(status, 16'($urandom), 1'b0, 1'b1);
      end else if (kind < 78) begin
        push_frame(status, 16'($urandom), 1'b1, 1'b0);
      end else if (kind < 86) begin
        // frame cut short
        push_byte(mfp_pkg::HDR0);
        push_byte(mfp_pkg::HDR1);
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom));
      end else if (kind < 96) begin
        repeat ($urandom_range(1, 5)) push_byte(noise_byte());
      end else begin
        // doubled first header byte
        push_byte(mfp_pkg::HDR0);
        push_frame(status, 16'($urandom), 1'b1, 1'b1);
      end
    end
    total_bytes = rx_bytes_pending.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (bytes_accepted < total_bytes) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // byte driver: payload and valid hold while stalled
  always @(posedge clk) begin
    if (!rst) begin
      if (rx_valid && !rx_stall) begin
        deframe_byte(rx_byte);
        bytes_accepted++;
      end
      if (!rx_valid || !rx_stall) begin
        if (rx_gap > 0) begin
          rx_gap--;
          rx_valid <= 1'b0;
        end else if (rx_bytes_pending.size() == 0 ||
                     (rx_bytes_pending[0].drain && frames_due.size() != 0)) begin
          rx_valid <= 1'b0;
        end else begin
          next_item = rx_bytes_pending.pop_front();
          rx_byte  <= next_item.data;
          rx_valid <= 1'b1;
          // idle burst after this transfer, none near the end
          if (rx_bytes_pending.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(1, 4);
          end
        end
      end
    end
  end

  // frame monitor and result-side stall bursts
  always @(posedge clk) begin
    if (rst) begin
      frame_stall <= 1'b0;
    end else begin
      if (frame_valid && !frame_stall) begin
        if (frames_due.size() == 0) begin
          $display("%0t: frame transfer with none expected, actual status %0h position %0h",
                   $time, mirror_status, position);
          mismatches++;
        end else begin
          got_frame = frames_due.pop_front();
          check_field("checksum_ok", 32'(got_frame.ok), 32'(checksum_ok));
          check_field("mirror_status", 32'(got_frame.status), 32'(mirror_status));
          check_field("mirror_fault", 32'(got_frame.fault), 32'(mirror_fault));
          check_field("position", {16'h0000, got_frame.position}, {16'h0000, position});
          check_field("frames_seen", got_frame.frames, frames_seen);
          check_field("checksum_errors", got_frame.errors, checksum_errors);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        frame_stall <= 1'b1;
      end else if (rx_bytes_pending.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        frame_stall <= 1'b1;
      end else begin
        frame_stall <= 1'b0;
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

endmodule
